// File: rtl/wwm_pkg.sv
`timescale 1ns / 1ps

package wwm_pkg;

    // field widths
    localparam int ACTION_W = 2;
    localparam int IDX_W    = 7;
    localparam int SAMPLE_W = 8;
    localparam int CFG_IDX_W = 3;
    localparam int PW_W     = 7;
    localparam int NUM_WAVES = 5;

    // wave shape and mix constants
    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int SAMPLE_MIN    = -127;
    localparam int SAMPLE_MAX    = 127;
    localparam int MIX_AMPLITUDE = 127;

    // mix arithmetic widths
    localparam int PROD_W    = 2 * SAMPLE_W;
    localparam int MAG_W     = PROD_W - 1;
    localparam int DIV_SHIFT = 22;
    localparam int MULT_W    = DIV_SHIFT + 1;
    localparam int FULL_W    = MAG_W + MULT_W;

    // reciprocal of the mix amplitude, rounded up, exact for magnitudes below 2^MAG_W
    localparam logic [MULT_W-1:0] DIV_MULT =
        MULT_W'(((1 << DIV_SHIFT) + MIX_AMPLITUDE - 1) / MIX_AMPLITUDE);

    // item actions
    typedef enum logic [ACTION_W-1:0] {
        ACT_PLAY        = 2'd0,
        ACT_LOAD_RANDOM = 2'd1,
        ACT_LOAD_NOISE  = 2'd2
    } t_action;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIANGLE_LEVEL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAWTOOTH_LEVEL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_LEVEL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_LEVEL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_LEVEL    = 3'd5;

    // wave slots in the mix
    localparam int WAVE_TRI = 0;
    localparam int WAVE_SAW = 1;
    localparam int WAVE_SQR = 2;
    localparam int WAVE_RND = 3;
    localparam int WAVE_NSE = 4;

    // register reset values
    localparam logic [PW_W-1:0]            PULSE_WIDTH_RST = 7'd32;
    localparam logic signed [SAMPLE_W-1:0] TRI_LEVEL_RST   = 8'sd127;
    localparam logic signed [SAMPLE_W-1:0] LEVEL_RST       = 8'sd0;

endpackage

// File: rtl/wwm_ram.sv
`timescale 1ns / 1ps

module wwm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/wavetable_waveform_mixer.sv
`timescale 1ns / 1ps
// Throughput: one item per cycle, through a five-stage pipe (table read, wave shapes,
// level multiply, reciprocal divide, sum); the whole pipe holds while the output stalls.
// Reset: synchronous active low; registers return to their defaults and the valid
// bits of both tables clear, so every entry reads as zero until loaded.

module wavetable_waveform_mixer #(
    parameter int TABLE_ENTRIES = wwm_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input item channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [wwm_pkg::ACTION_W-1:0]      i_action,
    input  logic [wwm_pkg::IDX_W-1:0]         i_index,
    input  logic signed [wwm_pkg::SAMPLE_W-1:0] i_load_value,
    // result item channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [wwm_pkg::SAMPLE_W-1:0] o_sample,
    // configuration writes
    input  logic                              i_cfg_we,
    input  logic [wwm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [wwm_pkg::SAMPLE_W-1:0]      i_cfg_data
);

    import wwm_pkg::*;

    localparam int AW   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int HALF = TABLE_ENTRIES / 2;
    localparam int REST = TABLE_ENTRIES - HALF;

    // wave shape constants; the sample ones are taken modulo 256, the index ones in IDX_W bits
    localparam logic [SAMPLE_W-1:0] MIN8      = SAMPLE_W'(SAMPLE_MIN);
    localparam logic [SAMPLE_W-1:0] MAX8      = SAMPLE_W'(SAMPLE_MAX);
    localparam logic [SAMPLE_W-1:0] FALL_BASE = SAMPLE_W'(SAMPLE_MAX - 1);
    localparam logic [SAMPLE_W-1:0] RISE_STEP = SAMPLE_W'((SAMPLE_MAX - SAMPLE_MIN) / HALF);
    localparam logic [SAMPLE_W-1:0] FALL_STEP = SAMPLE_W'((SAMPLE_MIN - SAMPLE_MAX) / REST);
    localparam logic [SAMPLE_W-1:0] SAW_STEP  =
        SAMPLE_W'((SAMPLE_MAX - SAMPLE_MIN) / TABLE_ENTRIES);
    localparam logic [IDX_W-1:0]    HALF_IDX  = IDX_W'(HALF);
    localparam logic [IDX_W-1:0]    TABLE_IDX = IDX_W'(TABLE_ENTRIES);

    // configuration registers
    logic [PW_W-1:0]            r_pulse_width;
    logic signed [SAMPLE_W-1:0] r_level [NUM_WAVES];

    // table valid bits
    logic [TABLE_ENTRIES-1:0] r_rnd_vld;
    logic [TABLE_ENTRIES-1:0] r_nse_vld;

    // pipe control
    logic            w_adv;
    logic            w_accept;
    logic            w_in_range;
    logic [AW-1:0]   w_addr;
    logic            w_play;
    logic            w_rnd_we;
    logic            w_nse_we;

    // stage a: index and table read
    logic                r_a_vld;
    logic [IDX_W-1:0]    r_a_idx;
    logic                r_a_rnd_ok;
    logic                r_a_nse_ok;
    logic [SAMPLE_W-1:0] w_rnd_q;
    logic [SAMPLE_W-1:0] w_nse_q;

    // stage b: wave values
    logic                       r_b_vld;
    logic signed [SAMPLE_W-1:0] r_b_wave [NUM_WAVES];
    logic [SAMPLE_W-1:0]        n_b_wave [NUM_WAVES];
    logic [SAMPLE_W-1:0]        w_i8;

    // stage c: level products
    logic                     r_c_vld;
    logic signed [PROD_W-1:0] r_c_prod [NUM_WAVES];

    // stage d: truncated quotients, low byte and sign
    logic                r_d_vld;
    logic [SAMPLE_W-1:0] r_d_quo [NUM_WAVES];
    logic                r_d_neg [NUM_WAVES];

    // output register
    logic                r_o_vld;
    logic [SAMPLE_W-1:0] r_o_sample;
    logic [SAMPLE_W-1:0] n_o_sample;

    // handshake: the pipe moves as one whenever the output register can take a result
    assign w_adv      = !r_o_vld || !i_stall;
    assign o_stall    = !w_adv;
    assign w_accept   = i_valid && w_adv;
    assign w_in_range = i_index < TABLE_IDX;
    assign w_addr     = i_index[AW-1:0];
    assign w_play     = w_accept && w_in_range && (i_action == ACT_PLAY);
    assign w_rnd_we   = w_accept && w_in_range && (i_action == ACT_LOAD_RANDOM);
    assign w_nse_we   = w_accept && w_in_range && (i_action == ACT_LOAD_NOISE);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_width <= PULSE_WIDTH_RST;
            r_level[WAVE_TRI] <= TRI_LEVEL_RST;
            r_level[WAVE_SAW] <= LEVEL_RST;
            r_level[WAVE_SQR] <= LEVEL_RST;
            r_level[WAVE_RND] <= LEVEL_RST;
            r_level[WAVE_NSE] <= LEVEL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PULSE_WIDTH:    r_pulse_width     <= i_cfg_data[PW_W-1:0];
                CFG_TRIANGLE_LEVEL: r_level[WAVE_TRI] <= signed'(i_cfg_data);
                CFG_SAWTOOTH_LEVEL: r_level[WAVE_SAW] <= signed'(i_cfg_data);
                CFG_SQUARE_LEVEL:   r_level[WAVE_SQR] <= signed'(i_cfg_data);
                CFG_RANDOM_LEVEL:   r_level[WAVE_RND] <= signed'(i_cfg_data);
                CFG_NOISE_LEVEL:    r_level[WAVE_NSE] <= signed'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // table entries start out unloaded and read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rnd_vld <= '0;
            r_nse_vld <= '0;
        end else begin
            if (w_rnd_we) begin
                r_rnd_vld[w_addr] <= 1'b1;
            end
            if (w_nse_we) begin
                r_nse_vld[w_addr] <= 1'b1;
            end
        end
    end

    wwm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_random_ram (
        .i_clk   (i_clk),
        .i_we    (w_rnd_we),
        .i_waddr (w_addr),
        .i_wdata (i_load_value),
        .i_re    (w_adv),
        .i_raddr (w_addr),
        .o_rdata (w_rnd_q)
    );

    wwm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_noise_ram (
        .i_clk   (i_clk),
        .i_we    (w_nse_we),
        .i_waddr (w_addr),
        .i_wdata (i_load_value),
        .i_re    (w_adv),
        .i_raddr (w_addr),
        .o_rdata (w_nse_q)
    );

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else if (w_adv) begin
            r_a_vld <= w_play;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
            r_o_vld <= r_d_vld;
        end
    end

    // stage a payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_idx    <= i_index;
            r_a_rnd_ok <= w_in_range && r_rnd_vld[w_addr];
            r_a_nse_ok <= w_in_range && r_nse_vld[w_addr];
        end
    end

    // wave shapes at the index, modulo 256
    assign w_i8 = {1'b0, r_a_idx};

    always_comb begin
        if (r_a_idx < HALF_IDX) begin
            n_b_wave[WAVE_TRI] = SAMPLE_W'(MIN8 + w_i8 * RISE_STEP);
        end else begin
            n_b_wave[WAVE_TRI] =
                SAMPLE_W'(FALL_BASE + (w_i8 - {1'b0, HALF_IDX}) * FALL_STEP);
        end
        n_b_wave[WAVE_SAW] = SAMPLE_W'(MIN8 + w_i8 * SAW_STEP);
        n_b_wave[WAVE_SQR] = (r_a_idx < r_pulse_width) ? MIN8 : MAX8;
        n_b_wave[WAVE_RND] = r_a_rnd_ok ? w_rnd_q : '0;
        n_b_wave[WAVE_NSE] = r_a_nse_ok ? w_nse_q : '0;
    end

    // per wave: level multiply, then divide by the mix amplitude toward zero
    for (genvar k = 0; k < NUM_WAVES; k++) begin : g_wave
        logic [MAG_W-1:0]  w_mag;
        logic [FULL_W-1:0] w_full;

        assign w_mag  = r_c_prod[k][PROD_W-1] ? MAG_W'(-r_c_prod[k]) : MAG_W'(r_c_prod[k]);
        assign w_full = FULL_W'(w_mag) * FULL_W'(DIV_MULT);

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_b_wave[k] <= signed'(n_b_wave[k]);
                r_c_prod[k] <= PROD_W'(r_b_wave[k]) * PROD_W'(r_level[k]);
                r_d_quo[k]  <= w_full[DIV_SHIFT +: SAMPLE_W];
                r_d_neg[k]  <= r_c_prod[k][PROD_W-1];
            end
        end
    end

    // signed sum of the five terms, wrapped to 8 bits
    always_comb begin
        n_o_sample = '0;
        for (int k = 0; k < NUM_WAVES; k++) begin
            n_o_sample = n_o_sample + (r_d_neg[k] ? SAMPLE_W'(-r_d_quo[k]) : r_d_quo[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_o_sample <= n_o_sample;
        end
    end

    assign o_valid  = r_o_vld;
    assign o_sample = signed'(r_o_sample);

    // a waiting result always holds back the input
    a_stall_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |-> o_stall)
        else $error("input taken while a result waits");

    // an empty output register never blocks the pipe
    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("pipe blocked with empty output");

    // a play item leaves the table valid bits alone
    a_play_keeps_tables: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (i_action == ACT_PLAY) |=> $stable(r_rnd_vld) && $stable(r_nse_vld))
        else $error("table valid bits changed by a play item");

endmodule

// File: test/tb_wavetable_waveform_mixer.sv
`timescale 1ns / 1ps

module tb_wavetable_waveform_mixer;

    import wwm_pkg::*;

    localparam int TABLE_ENTRIES  = TABLE_ENTRIES_DEF;
    localparam int IDLE_PCT       = 23;
    localparam int HOLDOFF_CYCLES = 80;
    localparam int SETTLE_CYCLES  = 10;
    localparam int QUIET_LIMIT    = 2000;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 200;
    localparam int MAX_PRINTED    = 20;

    // action code with no meaning to the block
    localparam logic [ACTION_W-1:0] ACT_UNKNOWN = 2'd3;

    // register indexes past the end of the register list
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam logic signed [SAMPLE_W-1:0] LEVEL_MIN = -8'sd128;
    localparam logic signed [SAMPLE_W-1:0] LEVEL_MAX = 8'sd127;

    localparam logic [CFG_IDX_W-1:0] LEVEL_REGS [NUM_WAVES] = '{
        CFG_TRIANGLE_LEVEL, CFG_SAWTOOTH_LEVEL, CFG_SQUARE_LEVEL,
        CFG_RANDOM_LEVEL, CFG_NOISE_LEVEL
    };

    typedef struct {
        logic [IDX_W-1:0]           index;
        logic signed [SAMPLE_W-1:0] sample;
    } t_mix_expect;

    // mixer prediction and sample queue
    class mix_scoreboard;
        logic [PW_W-1:0]            pulse_width;
        logic signed [SAMPLE_W-1:0] levels [NUM_WAVES];
        logic signed [SAMPLE_W-1:0] random_tab [TABLE_ENTRIES];
        logic signed [SAMPLE_W-1:0] noise_tab [TABLE_ENTRIES];
        t_mix_expect                expected_samples [$];
        int mismatches;
        int plays;
        int loads;
        int ignored;
        int samples_checked;

        function new();
            pulse_width = PULSE_WIDTH_RST;
            levels[WAVE_TRI] = TRI_LEVEL_RST;
            levels[WAVE_SAW] = LEVEL_RST;
            levels[WAVE_SQR] = LEVEL_RST;
            levels[WAVE_RND] = LEVEL_RST;
            levels[WAVE_NSE] = LEVEL_RST;
            foreach (random_tab[k]) random_tab[k] = '0;
            foreach (noise_tab[k]) noise_tab[k] = '0;
            mismatches = 0;
            plays = 0;
            loads = 0;
            ignored = 0;
            samples_checked = 0;
        endfunction

        function int to_s8(int v);
            logic signed [SAMPLE_W-1:0] b;
            b = v[SAMPLE_W-1:0];
            return b;
        endfunction

        // triangle climbs from the minimum, then falls from one below the maximum
        function int tri_wave(int i);
            int half;
            int slope;
            half = TABLE_ENTRIES / 2;
            if (i < half) begin
                slope = to_s8((SAMPLE_MAX - SAMPLE_MIN) / half);
                return to_s8(SAMPLE_MIN + i * slope);
            end
            slope = to_s8((SAMPLE_MIN - SAMPLE_MAX) / (TABLE_ENTRIES - half));
            return to_s8(to_s8(SAMPLE_MAX - 1) + (i - half) * slope);
        endfunction

        function int saw_wave(int i);
            int slope;
            slope = to_s8((SAMPLE_MAX - SAMPLE_MIN) / TABLE_ENTRIES);
            return to_s8(SAMPLE_MIN + i * slope);
        endfunction

        function int square_wave(int i);
            return (i < int'(pulse_width)) ? SAMPLE_MIN : SAMPLE_MAX;
        endfunction

        function logic signed [SAMPLE_W-1:0] mix_at(int i);
            int waves [NUM_WAVES];
            int sum;
            waves[WAVE_TRI] = tri_wave(i);
            waves[WAVE_SAW] = saw_wave(i);
            waves[WAVE_SQR] = square_wave(i);
            waves[WAVE_RND] = int'(random_tab[i]);
            waves[WAVE_NSE] = int'(noise_tab[i]);
            sum = 0;
            for (int k = 0; k < NUM_WAVES; k++)
                sum += (waves[k] * int'(levels[k])) / MIX_AMPLITUDE;
            return sum[SAMPLE_W-1:0];
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] data);
            case (idx)
                CFG_PULSE_WIDTH:    pulse_width = data[PW_W-1:0];
                CFG_TRIANGLE_LEVEL: levels[WAVE_TRI] = data;
                CFG_SAWTOOTH_LEVEL: levels[WAVE_SAW] = data;
                CFG_SQUARE_LEVEL:   levels[WAVE_SQR] = data;
                CFG_RANDOM_LEVEL:   levels[WAVE_RND] = data;
                CFG_NOISE_LEVEL:    levels[WAVE_NSE] = data;
                default: ;
            endcase
        endfunction

        // accepted input item: update tables or queue the expected sample; others count as ignored
        function void note_item(logic [ACTION_W-1:0] action, logic [IDX_W-1:0] index,
                                logic signed [SAMPLE_W-1:0] value);
            t_mix_expect e;
            if (int'(index) >= TABLE_ENTRIES) begin
                ignored++;
                return;
            end
            case (action)
                ACT_PLAY: begin
                    e.index = index;
                    e.sample = mix_at(int'(index));
                    expected_samples.push_back(e);
                    plays++;
                end
                ACT_LOAD_RANDOM: begin
                    random_tab[index] = value;
                    loads++;
                end
                ACT_LOAD_NOISE: begin
                    noise_tab[index] = value;
                    loads++;
                end
                default: ignored++;
            endcase
        endfunction

        task report(string msg);
            if (mismatches < MAX_PRINTED)
                $display("%0t mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task check_sample(logic signed [SAMPLE_W-1:0] got);
            t_mix_expect e;
            if (expected_samples.size() == 0) begin
                report($sformatf("sample %0d with no play item waiting", got));
                return;
            end
            e = expected_samples.pop_front();
            samples_checked++;
            if (got !== e.sample)
                report($sformatf("index %0d sample %0d, expected %0d", e.index, got, e.sample));
        endtask

        task check_drained();
            if (expected_samples.size() != 0)
                report($sformatf("%0d expected samples never came out",
                                 expected_samples.size()));
        endtask

        function int pending();
            return expected_samples.size();
        endfunction
    endclass

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_stall;
    logic [ACTION_W-1:0]          i_action;
    logic [IDX_W-1:0]             i_index;
    logic signed [SAMPLE_W-1:0]   i_load_value;
    logic                         o_valid;
    logic                         i_stall;
    logic signed [SAMPLE_W-1:0]   o_sample;
    logic                         i_cfg_we;
    logic [CFG_IDX_W-1:0]         i_cfg_index;
    logic [SAMPLE_W-1:0]          i_cfg_data;

    mix_scoreboard sb = new();
    bit steady_flow = 1'b0;
    bit holdoff_request = 1'b0;
    int quiet_cycles = 0;
    int settings_used = 0;

    wavetable_waveform_mixer dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_action     (i_action),
        .i_index      (i_index),
        .i_load_value (i_load_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_sample     (o_sample),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // clock
    always #2 i_clk = ~i_clk;

    // monitor both channels at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (i_rst_n && i_valid && !o_stall)
            sb.note_item(i_action, i_index, i_load_value);
        if (i_rst_n && o_valid && !i_stall)
            sb.check_sample(o_sample);
    end

    // watchdog
    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles with no item moving", QUIET_LIMIT);
        $display("wavetable_waveform_mixer regression: fail");
        $finish;
    end

    // result receiver: random stalls, plus a long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holdoff_request) begin
                holdoff_request = 1'b0;
                hold_left = HOLDOFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= !steady_flow && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // offer one item and wait until it is taken
    task automatic send_item(logic [ACTION_W-1:0] action, logic [IDX_W-1:0] index,
                             logic signed [SAMPLE_W-1:0] value);
        while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= action;
        i_index <= index;
        i_load_value <= value;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // drop valid and let the pipe empty
    task automatic settle();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        sb.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    task automatic end_writes();
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_level();
        case ($urandom_range(7))
            0: return LEVEL_MIN;
            1: return LEVEL_MAX;
            2: return '0;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_width();
        case ($urandom_range(5))
            0: return '0;
            1: return {1'b0, {PW_W{1'b1}}};
            2: return SAMPLE_W'(TABLE_ENTRIES);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // random register setting, spare indexes now and then
    task automatic random_settings();
        write_reg(CFG_PULSE_WIDTH, pick_width());
        for (int k = 0; k < NUM_WAVES; k++)
            write_reg(LEVEL_REGS[k], pick_level());
        if ($urandom_range(1))
            write_reg($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI, SAMPLE_W'($urandom));
        end_writes();
    endtask

    // mostly plays and loads in the table, some unknown and out-of-table items
    task automatic random_phase(int count, bit with_holdoff);
        int r;
        logic [ACTION_W-1:0] act;
        logic [IDX_W-1:0] idx;
        random_settings();
        for (int n = 0; n < count; n++) begin
            if (with_holdoff && (n == 0 || n == count / 2))
                holdoff_request = 1'b1;
            r = $urandom_range(99);
            idx = IDX_W'($urandom_range(TABLE_ENTRIES - 1));
            if (r < 55)
                act = ACT_PLAY;
            else if (r < 75)
                act = ACT_LOAD_RANDOM;
            else if (r < 90)
                act = ACT_LOAD_NOISE;
            else if (r < 95)
                act = ACT_UNKNOWN;
            else begin
                act = ACTION_W'($urandom);
                idx = IDX_W'($urandom_range((1 << IDX_W) - 1, TABLE_ENTRIES));
            end
            send_item(act, idx, SAMPLE_W'($urandom));
        end
        settle();
    endtask

    // stimulus
    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_action = ACT_PLAY;
        i_index = '0;
        i_load_value = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_PULSE_WIDTH;
        i_cfg_data = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: table edges, loads, ignored items
        send_item(ACT_PLAY, 0, 8'sd0);
        send_item(ACT_LOAD_RANDOM, 0, LEVEL_MIN);
        send_item(ACT_LOAD_RANDOM, IDX_W'(TABLE_ENTRIES - 1), LEVEL_MAX);
        send_item(ACT_LOAD_NOISE, 0, LEVEL_MAX);
        send_item(ACT_LOAD_NOISE, IDX_W'(TABLE_ENTRIES - 1), LEVEL_MIN);
        send_item(ACT_LOAD_RANDOM, IDX_W'(TABLE_ENTRIES), 8'sd55);
        send_item(ACT_LOAD_NOISE, IDX_W'((1 << IDX_W) - 1), -8'sd9);
        send_item(ACT_UNKNOWN, 1, 8'sd17);
        send_item(ACT_UNKNOWN, IDX_W'((1 << IDX_W) - 1), -8'sd1);
        send_item(ACT_PLAY, 1, -8'sd1);
        send_item(ACT_PLAY, IDX_W'(TABLE_ENTRIES / 2 - 1), LEVEL_MAX);
        send_item(ACT_PLAY, IDX_W'(TABLE_ENTRIES / 2), LEVEL_MIN);
        send_item(ACT_PLAY, IDX_W'(TABLE_ENTRIES / 2 + 1), 8'sd0);
        send_item(ACT_PLAY, IDX_W'(TABLE_ENTRIES - 1), -8'sd1);
        send_item(ACT_PLAY, IDX_W'(TABLE_ENTRIES), 8'sd0);
        send_item(ACT_PLAY, IDX_W'((1 << IDX_W) - 1), 8'sd0);
        settle();

        // every level at the minimum, square low across the table
        write_reg(CFG_SPARE_LO, 8'hff);
        write_reg(CFG_SPARE_HI, 8'h5a);
        write_reg(CFG_PULSE_WIDTH, {1'b1, {PW_W{1'b1}}});
        for (int k = 0; k < NUM_WAVES; k++)
            write_reg(LEVEL_REGS[k], LEVEL_MIN);
        end_writes();
        send_item(ACT_PLAY, 0, 8'sd0);
        send_item(ACT_PLAY, IDX_W'(TABLE_ENTRIES / 2), 8'sd0);
        send_item(ACT_PLAY, IDX_W'(TABLE_ENTRIES - 1), 8'sd0);
        settle();

        // every level at the maximum, square high across the table
        write_reg(CFG_PULSE_WIDTH, '0);
        for (int k = 0; k < NUM_WAVES; k++)
            write_reg(LEVEL_REGS[k], LEVEL_MAX);
        end_writes();
        send_item(ACT_PLAY, 0, 8'sd0);
        send_item(ACT_PLAY, IDX_W'(TABLE_ENTRIES - 1), 8'sd0);
        settle();

        // random phases: two of the six with free flow, one of those with a receiver hold-off
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            steady_flow = (p == 1) || (p == 3);
            random_phase(PHASE_ITEMS, p == 3);
        end
        steady_flow = 1'b0;

        sb.check_drained();
        $display("covered %0d plays, %0d table loads, %0d ignored items over %0d settings",
                 sb.plays, sb.loads, sb.ignored, settings_used);
        $display("checked %0d samples, including a %0d-cycle output hold-off",
                 sb.samples_checked, HOLDOFF_CYCLES);
        if (sb.mismatches == 0)
            $display("wavetable_waveform_mixer regression: pass");
        else
            $display("wavetable_waveform_mixer regression: fail");
        $finish;
    end

endmodule
